@@ rtl/dnsmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser package
// Shared phase codes, result record type and wire-format constants.
// ----------------------------------------------------------------------------
package dnsmp_pkg;

    // Default bound on the inline name length.
    localparam int NAME_LIMIT_DEFAULT = 256;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_QUESTION  = 2'd1;
    localparam logic [1:0] KIND_ANSWER    = 2'd2;
    localparam logic [1:0] KIND_TRUNCATED = 2'd3;

    // Record types with captured data.
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] TYPE_AAAA = 16'd28;

    // Address data lengths in bytes, and the split point for AAAA.
    localparam logic [15:0] A_ADDR_LEN    = 16'd4;
    localparam logic [15:0] AAAA_ADDR_LEN = 16'd16;
    localparam logic [15:0] AAAA_HALF     = 16'd8;

    // Name label byte decoding.
    localparam logic [7:0] PTR_MARK   = 8'hC0;
    localparam logic [7:0] LABEL_MASK = 8'h3F;

    // Byte positions within fixed sections.
    localparam logic [4:0] HDR_WORDS_END = 5'd8;
    localparam logic [4:0] HDR_LAST      = 5'd11;
    localparam logic [4:0] TC_END        = 5'd4;
    localparam logic [4:0] Q_FIXED_LAST  = 5'd3;
    localparam logic [4:0] TTL_END       = 5'd8;
    localparam logic [4:0] A_FIXED_LAST  = 5'd9;

    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_Q_NAME  = 9'b000000010,
        PH_Q_PTR   = 9'b000000100,
        PH_Q_FIXED = 9'b000001000,
        PH_A_NAME  = 9'b000010000,
        PH_A_PTR   = 9'b000100000,
        PH_A_FIXED = 9'b001000000,
        PH_A_RDATA = 9'b010000000,
        PH_DONE    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ident_or_type;
        logic [15:0] flags_or_class;
        logic [31:0] time_to_live;
        logic [15:0] data_length;
        logic [15:0] question_total;
        logic [15:0] answer_total;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic        name_compressed;
        logic [13:0] name_pointer;
        logic [7:0]  name_length;
    } result_t;

endpackage

@@ rtl/dnsmp_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser byte engine
// Holds the parse state and advances it by one message byte per accepted
// transaction, producing at most one result record for that byte.
// ----------------------------------------------------------------------------
module dnsmp_parse
    import dnsmp_pkg::*;
#(
    parameter int NAME_LIMIT = NAME_LIMIT_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [7:0] NAME_CAP = 8'((NAME_LIMIT - 1 < 255) ? NAME_LIMIT - 1 : 255);

    phase_t      phase_reg,      phase_next;
    logic [4:0]  byte_cnt_reg,   byte_cnt_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [7:0]  name_cnt_reg,   name_cnt_next;
    logic        ptr_seen_reg,   ptr_seen_next;
    logic [13:0] ptr_off_reg,    ptr_off_next;
    logic [15:0] q_left_reg,     q_left_next;
    logic [15:0] a_left_reg,     a_left_next;
    logic [15:0] hdr_id_reg,     hdr_id_next;
    logic [15:0] hdr_flags_reg,  hdr_flags_next;
    logic [15:0] rec_type_reg,   rec_type_next;
    logic [15:0] rec_class_reg,  rec_class_next;
    logic [31:0] rec_ttl_reg,    rec_ttl_next;
    logic [15:0] rec_len_reg,    rec_len_next;
    logic [15:0] rdata_left_reg, rdata_left_next;
    logic [63:0] addr_hi_reg,    addr_hi_next;
    logic [63:0] addr_lo_reg,    addr_lo_next;

    always_comb begin
        logic advance;
        logic finish;
        logic is_name;
        logic [4:0] cnt_inc;

        advance         = 1'b0;
        finish          = 1'b0;
        is_name         = 1'b0;
        cnt_inc         = byte_cnt_reg + 5'd1;
        res_valid       = 1'b0;
        res             = '0;
        phase_next      = phase_reg;
        byte_cnt_next   = byte_cnt_reg;
        label_left_next = label_left_reg;
        name_cnt_next   = name_cnt_reg;
        ptr_seen_next   = ptr_seen_reg;
        ptr_off_next    = ptr_off_reg;
        q_left_next     = q_left_reg;
        a_left_next     = a_left_reg;
        hdr_id_next     = hdr_id_reg;
        hdr_flags_next  = hdr_flags_reg;
        rec_type_next   = rec_type_reg;
        rec_class_next  = rec_class_reg;
        rec_ttl_next    = rec_ttl_reg;
        rec_len_next    = rec_len_reg;
        rdata_left_next = rdata_left_reg;
        addr_hi_next    = addr_hi_reg;
        addr_lo_next    = addr_lo_reg;

        case (phase_reg)
            PH_HEADER: begin
                if (byte_cnt_reg < HDR_WORDS_END) begin
                    case (byte_cnt_reg[2:1])
                        2'd0:    hdr_id_next    = {hdr_id_reg[7:0], data_byte};
                        2'd1:    hdr_flags_next = {hdr_flags_reg[7:0], data_byte};
                        2'd2:    q_left_next    = {q_left_reg[7:0], data_byte};
                        default: a_left_next    = {a_left_reg[7:0], data_byte};
                    endcase
                end
                byte_cnt_next = cnt_inc;
                if (byte_cnt_reg == HDR_LAST) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_HEADER;
                    res.ident_or_type  = hdr_id_next;
                    res.flags_or_class = hdr_flags_next;
                    res.question_total = q_left_next;
                    res.answer_total   = a_left_next;
                    byte_cnt_next      = '0;
                    advance            = 1'b1;
                end
            end
            PH_Q_NAME, PH_A_NAME: begin
                is_name = 1'b1;
            end
            PH_Q_PTR, PH_A_PTR: begin
                ptr_off_next  = ptr_off_reg | {6'd0, data_byte};
                phase_next    = (phase_reg == PH_Q_PTR) ? PH_Q_FIXED : PH_A_FIXED;
                byte_cnt_next = '0;
            end
            PH_Q_FIXED: begin
                if (byte_cnt_reg[1]) rec_class_next = {rec_class_reg[7:0], data_byte};
                else                 rec_type_next  = {rec_type_reg[7:0], data_byte};
                byte_cnt_next = cnt_inc;
                if (byte_cnt_reg == Q_FIXED_LAST) begin
                    res_valid           = 1'b1;
                    res.kind            = KIND_QUESTION;
                    res.ident_or_type   = rec_type_next;
                    res.flags_or_class  = rec_class_next;
                    res.name_compressed = ptr_seen_reg;
                    res.name_pointer    = ptr_off_reg;
                    res.name_length     = name_cnt_reg;
                    if (q_left_reg != 16'd0) q_left_next = q_left_reg - 16'd1;
                    advance = 1'b1;
                end
            end
            PH_A_FIXED: begin
                if (byte_cnt_reg < TC_END) begin
                    if (byte_cnt_reg[1]) rec_class_next = {rec_class_reg[7:0], data_byte};
                    else                 rec_type_next  = {rec_type_reg[7:0], data_byte};
                end else if (byte_cnt_reg < TTL_END) begin
                    rec_ttl_next = {rec_ttl_reg[23:0], data_byte};
                end else begin
                    rec_len_next = {rec_len_reg[7:0], data_byte};
                end
                byte_cnt_next = cnt_inc;
                if (byte_cnt_reg == A_FIXED_LAST) begin
                    if (rec_type_next == TYPE_A)         rdata_left_next = A_ADDR_LEN;
                    else if (rec_type_next == TYPE_AAAA) rdata_left_next = AAAA_ADDR_LEN;
                    else                                 rdata_left_next = rec_len_next;
                    byte_cnt_next = '0;
                    if (rdata_left_next == 16'd0) finish = 1'b1;
                    else                          phase_next = PH_A_RDATA;
                end
            end
            PH_A_RDATA: begin
                if (rec_type_reg == TYPE_A) begin
                    addr_lo_next = {32'd0, addr_lo_reg[23:0], data_byte};
                end else if (rec_type_reg == TYPE_AAAA) begin
                    if (rdata_left_reg > AAAA_HALF)
                        addr_hi_next = {addr_hi_reg[55:0], data_byte};
                    else
                        addr_lo_next = {addr_lo_reg[55:0], data_byte};
                end
                if (rdata_left_reg != 16'd0) rdata_left_next = rdata_left_reg - 16'd1;
                if (rdata_left_next == 16'd0) finish = 1'b1;
            end
            default: begin
                // Finished: trailing sections are skipped until the last byte.
            end
        endcase

        if (is_name) begin
            if (label_left_reg != 6'd0) begin
                if (name_cnt_reg < NAME_CAP) name_cnt_next = name_cnt_reg + 8'd1;
                label_left_next = label_left_reg - 6'd1;
            end else if (data_byte == 8'd0) begin
                phase_next    = (phase_reg == PH_Q_NAME) ? PH_Q_FIXED : PH_A_FIXED;
                byte_cnt_next = '0;
            end else if ((data_byte & PTR_MARK) == PTR_MARK) begin
                ptr_seen_next = 1'b1;
                ptr_off_next  = {data_byte[5:0], 8'd0};
                phase_next    = (phase_reg == PH_Q_NAME) ? PH_Q_PTR : PH_A_PTR;
            end else begin
                // A new label adds a dot, except before the first label.
                if (name_cnt_reg != 8'd0 && name_cnt_reg < NAME_CAP)
                    name_cnt_next = name_cnt_reg + 8'd1;
                label_left_next = 6'(data_byte & LABEL_MASK);
            end
        end

        if (finish) begin
            res_valid           = 1'b1;
            res.kind            = KIND_ANSWER;
            res.ident_or_type   = rec_type_next;
            res.flags_or_class  = rec_class_next;
            res.time_to_live    = rec_ttl_next;
            res.data_length     = rec_len_next;
            res.address_high    = addr_hi_next;
            res.address_low     = addr_lo_next;
            res.name_compressed = ptr_seen_reg;
            res.name_pointer    = ptr_off_reg;
            res.name_length     = name_cnt_reg;
            if (a_left_reg != 16'd0) a_left_next = a_left_reg - 16'd1;
            advance = 1'b1;
        end

        if (advance) begin
            if (q_left_next != 16'd0 || a_left_next != 16'd0) begin
                phase_next      = (q_left_next != 16'd0) ? PH_Q_NAME : PH_A_NAME;
                byte_cnt_next   = '0;
                label_left_next = '0;
                name_cnt_next   = '0;
                ptr_seen_next   = 1'b0;
                ptr_off_next    = '0;
                rec_type_next   = '0;
                rec_class_next  = '0;
                rec_ttl_next    = '0;
                rec_len_next    = '0;
                rdata_left_next = '0;
                addr_hi_next    = '0;
                addr_lo_next    = '0;
            end else begin
                phase_next = PH_DONE;
            end
        end

        // The final byte returns everything to reset; a message cut short
        // reports a single error record instead of its own result.
        if (end_of_message) begin
            if (phase_next != PH_DONE) begin
                res_valid = 1'b1;
                res       = '0;
                res.kind  = KIND_TRUNCATED;
            end
            phase_next      = PH_HEADER;
            byte_cnt_next   = '0;
            label_left_next = '0;
            name_cnt_next   = '0;
            ptr_seen_next   = 1'b0;
            ptr_off_next    = '0;
            q_left_next     = '0;
            a_left_next     = '0;
            hdr_id_next     = '0;
            hdr_flags_next  = '0;
            rec_type_next   = '0;
            rec_class_next  = '0;
            rec_ttl_next    = '0;
            rec_len_next    = '0;
            rdata_left_next = '0;
            addr_hi_next    = '0;
            addr_lo_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            byte_cnt_reg   <= '0;
            label_left_reg <= '0;
            name_cnt_reg   <= '0;
            ptr_seen_reg   <= 1'b0;
            ptr_off_reg    <= '0;
            q_left_reg     <= '0;
            a_left_reg     <= '0;
            hdr_id_reg     <= '0;
            hdr_flags_reg  <= '0;
            rec_type_reg   <= '0;
            rec_class_reg  <= '0;
            rec_ttl_reg    <= '0;
            rec_len_reg    <= '0;
            rdata_left_reg <= '0;
            addr_hi_reg    <= '0;
            addr_lo_reg    <= '0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            byte_cnt_reg   <= byte_cnt_next;
            label_left_reg <= label_left_next;
            name_cnt_reg   <= name_cnt_next;
            ptr_seen_reg   <= ptr_seen_next;
            ptr_off_reg    <= ptr_off_next;
            q_left_reg     <= q_left_next;
            a_left_reg     <= a_left_next;
            hdr_id_reg     <= hdr_id_next;
            hdr_flags_reg  <= hdr_flags_next;
            rec_type_reg   <= rec_type_next;
            rec_class_reg  <= rec_class_next;
            rec_ttl_reg    <= rec_ttl_next;
            rec_len_reg    <= rec_len_next;
            rdata_left_reg <= rdata_left_next;
            addr_hi_reg    <= addr_hi_next;
            addr_lo_reg    <= addr_lo_next;
        end
    end

endmodule

@@ rtl/dns_message_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser
// Parses the header, questions and answer records of a DNS message supplied
// one byte per transaction and reports one result record per completed part.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   data_byte, end_of_message
//   m_       out        m_valid / m_ready   one result record, twelve fields
//
// One byte is taken every cycle while s_ready is high; each accepted byte
// updates the byte engine, and the result it completes is registered for m_.
// Reset is synchronous and active low and returns the parser to the header.
// The result register is backed by a one-entry skid stage, so a byte is still
// taken while one result waits; s_ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module dns_message_parser_core
    import dnsmp_pkg::*;
#(
    parameter int NAME_LIMIT = NAME_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_ident_or_type,
    output logic [15:0] m_flags_or_class,
    output logic [31:0] m_time_to_live,
    output logic [15:0] m_data_length,
    output logic [15:0] m_question_total,
    output logic [15:0] m_answer_total,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low,
    output logic        m_name_compressed,
    output logic [13:0] m_name_pointer,
    output logic [7:0]  m_name_length
);

    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    dnsmp_parse #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (accept),
        .data_byte      (s_data_byte),
        .end_of_message (s_end_of_message),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept && res_valid;
                end
            end else if (accept && res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept && res_valid) begin
                out_data_reg <= res;
            end
        end else if (accept && res_valid) begin
            skid_data_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_data_reg.kind;
    assign m_ident_or_type   = out_data_reg.ident_or_type;
    assign m_flags_or_class  = out_data_reg.flags_or_class;
    assign m_time_to_live    = out_data_reg.time_to_live;
    assign m_data_length     = out_data_reg.data_length;
    assign m_question_total  = out_data_reg.question_total;
    assign m_answer_total    = out_data_reg.answer_total;
    assign m_address_high    = out_data_reg.address_high;
    assign m_address_low     = out_data_reg.address_low;
    assign m_name_compressed = out_data_reg.name_compressed;
    assign m_name_pointer    = out_data_reg.name_pointer;
    assign m_name_length     = out_data_reg.name_length;

    // The skid stage is only ever occupied behind a full result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    // The skid stage fills only when the output register was stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid stage filled without an output stall");

    // A truncation error is raised only by the final byte of a message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid && res.kind == KIND_TRUNCATED) |-> s_end_of_message)
        else $error("truncation result without end of message");

endmodule

@@ tb/tb_dns_message_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser core testbench
// Streams directed and random DNS messages into the parser one byte per
// transaction, with random gaps on the byte channel and random back-pressure
// on the result channel. A behavioural parser in the testbench predicts every
// result record, and each record that leaves the core is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_dns_message_parser_core
    import dnsmp_pkg::*;
();

    localparam int NAME_CAP     = (NAME_LIMIT_DEFAULT - 1 < 255) ? NAME_LIMIT_DEFAULT - 1 : 255;
    localparam int RANDOM_BYTES = 900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'h00;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_ident_or_type;
    logic [15:0] m_flags_or_class;
    logic [31:0] m_time_to_live;
    logic [15:0] m_data_length;
    logic [15:0] m_question_total;
    logic [15:0] m_answer_total;
    logic [63:0] m_address_high;
    logic [63:0] m_address_low;
    logic        m_name_compressed;
    logic [13:0] m_name_pointer;
    logic [7:0]  m_name_length;
    result_t     seen_record;

    // Parser state of the testbench's own model.
    phase_t      cur_phase;
    logic [4:0]  field_pos;
    logic [5:0]  label_left;
    logic [7:0]  name_chars;
    logic        ptr_seen;
    logic [13:0] ptr_offset;
    logic [15:0] pend_questions;
    logic [15:0] pend_answers;
    logic [15:0] hdr_ident;
    logic [15:0] hdr_flags;
    logic [15:0] rr_type;
    logic [15:0] rr_cls;
    logic [31:0] rr_ttl;
    logic [15:0] rr_rdlength;
    logic [15:0] rdata_left;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;

    result_t     pending_records[$];
    logic [7:0]  msg_bytes[$];
    int unsigned bytes_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    bit          send_idling    = 1'b0;
    bit          ready_idling   = 1'b0;

    dns_message_parser_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_message  (s_end_of_message),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_ident_or_type   (m_ident_or_type),
        .m_flags_or_class  (m_flags_or_class),
        .m_time_to_live    (m_time_to_live),
        .m_data_length     (m_data_length),
        .m_question_total  (m_question_total),
        .m_answer_total    (m_answer_total),
        .m_address_high    (m_address_high),
        .m_address_low     (m_address_low),
        .m_name_compressed (m_name_compressed),
        .m_name_pointer    (m_name_pointer),
        .m_name_length     (m_name_length)
    );

    assign seen_record = {m_kind, m_ident_or_type, m_flags_or_class, m_time_to_live,
                          m_data_length, m_question_total, m_answer_total,
                          m_address_high, m_address_low, m_name_compressed,
                          m_name_pointer, m_name_length};

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    task automatic start_name(input phase_t ph);
        cur_phase   = ph;
        field_pos   = '0;
        label_left  = '0;
        name_chars  = '0;
        ptr_seen    = 1'b0;
        ptr_offset  = '0;
        rr_type     = '0;
        rr_cls      = '0;
        rr_ttl      = '0;
        rr_rdlength = '0;
        rdata_left  = '0;
        addr_hi     = '0;
        addr_lo     = '0;
    endtask

    task automatic clear_parser();
        pend_questions = '0;
        pend_answers   = '0;
        hdr_ident      = '0;
        hdr_flags      = '0;
        start_name(PH_HEADER);
    endtask

    task automatic advance_section();
        if (pend_questions != 0) begin
            start_name(PH_Q_NAME);
        end else if (pend_answers != 0) begin
            start_name(PH_A_NAME);
        end else begin
            cur_phase = PH_DONE;
        end
    endtask

    task automatic count_name_char();
        if (name_chars < NAME_CAP) begin
            name_chars = name_chars + 8'd1;
        end
    endtask

    function automatic result_t record_result(input logic [1:0] kind);
        result_t rec;
        rec                 = '0;
        rec.kind            = kind;
        rec.ident_or_type   = rr_type;
        rec.flags_or_class  = rr_cls;
        if (kind == KIND_ANSWER) begin
            rec.time_to_live = rr_ttl;
            rec.data_length  = rr_rdlength;
            rec.address_high = addr_hi;
            rec.address_low  = addr_lo;
        end
        rec.name_compressed = ptr_seen;
        rec.name_pointer    = ptr_offset;
        rec.name_length     = name_chars;
        return rec;
    endfunction

    task automatic finish_answer(output result_t rec);
        rec = record_result(KIND_ANSWER);
        if (pend_answers != 0) begin
            pend_answers = pend_answers - 16'd1;
        end
        advance_section();
    endtask

    task automatic shift_type_class(input logic [7:0] b);
        if (field_pos[1] == 1'b0) begin
            rr_type = {rr_type[7:0], b};
        end else begin
            rr_cls = {rr_cls[7:0], b};
        end
    endtask

    task automatic name_byte(input logic [7:0] b, input phase_t ptr_ph, input phase_t fixed_ph);
        if (label_left != 0) begin
            count_name_char();
            label_left = label_left - 6'd1;
        end else if (b == 8'h00) begin
            cur_phase = fixed_ph;
            field_pos = '0;
        end else if ((b & PTR_MARK) == PTR_MARK) begin
            ptr_seen   = 1'b1;
            ptr_offset = {b[5:0], 8'h00};
            cur_phase  = ptr_ph;
        end else begin
            // Reserved label types fall through here; only the low six bits count.
            if (name_chars != 0) begin
                count_name_char();
            end
            label_left = b[5:0];
        end
    endtask

    task automatic parse_dns_byte(input logic [7:0] b, input logic last);
        result_t rec;
        logic    made;
        rec  = '0;
        made = 1'b0;
        case (cur_phase)
            PH_HEADER: begin
                if (field_pos < HDR_WORDS_END) begin
                    case (field_pos[2:1])
                        2'd0:    hdr_ident      = {hdr_ident[7:0], b};
                        2'd1:    hdr_flags      = {hdr_flags[7:0], b};
                        2'd2:    pend_questions = {pend_questions[7:0], b};
                        default: pend_answers   = {pend_answers[7:0], b};
                    endcase
                end
                field_pos = field_pos + 5'd1;
                if (field_pos > HDR_LAST) begin
                    rec.kind           = KIND_HEADER;
                    rec.ident_or_type  = hdr_ident;
                    rec.flags_or_class = hdr_flags;
                    rec.question_total = pend_questions;
                    rec.answer_total   = pend_answers;
                    made               = 1'b1;
                    field_pos          = '0;
                    advance_section();
                end
            end
            PH_Q_NAME: name_byte(b, PH_Q_PTR, PH_Q_FIXED);
            PH_A_NAME: name_byte(b, PH_A_PTR, PH_A_FIXED);
            PH_Q_PTR, PH_A_PTR: begin
                ptr_offset = ptr_offset | {6'd0, b};
                cur_phase  = (cur_phase == PH_Q_PTR) ? PH_Q_FIXED : PH_A_FIXED;
                field_pos  = '0;
            end
            PH_Q_FIXED: begin
                if (field_pos < TC_END) begin
                    shift_type_class(b);
                end
                field_pos = field_pos + 5'd1;
                if (field_pos > Q_FIXED_LAST) begin
                    rec  = record_result(KIND_QUESTION);
                    made = 1'b1;
                    if (pend_questions != 0) begin
                        pend_questions = pend_questions - 16'd1;
                    end
                    advance_section();
                end
            end
            PH_A_FIXED: begin
                if (field_pos < TC_END) begin
                    shift_type_class(b);
                end else if (field_pos < TTL_END) begin
                    rr_ttl = {rr_ttl[23:0], b};
                end else begin
                    rr_rdlength = {rr_rdlength[7:0], b};
                end
                field_pos = field_pos + 5'd1;
                if (field_pos > A_FIXED_LAST) begin
                    // Address records always take their natural size, whatever
                    // the length field claims.
                    if (rr_type == TYPE_A) begin
                        rdata_left = A_ADDR_LEN;
                    end else if (rr_type == TYPE_AAAA) begin
                        rdata_left = AAAA_ADDR_LEN;
                    end else begin
                        rdata_left = rr_rdlength;
                    end
                    field_pos = '0;
                    if (rdata_left == 0) begin
                        finish_answer(rec);
                        made = 1'b1;
                    end else begin
                        cur_phase = PH_A_RDATA;
                    end
                end
            end
            PH_A_RDATA: begin
                if (rr_type == TYPE_A) begin
                    addr_lo = {32'd0, addr_lo[23:0], b};
                end else if (rr_type == TYPE_AAAA) begin
                    if (rdata_left > AAAA_HALF) begin
                        addr_hi = {addr_hi[55:0], b};
                    end else begin
                        addr_lo = {addr_lo[55:0], b};
                    end
                end
                if (rdata_left != 0) begin
                    rdata_left = rdata_left - 16'd1;
                end
                if (rdata_left == 0) begin
                    finish_answer(rec);
                    made = 1'b1;
                end
            end
            default: ;
        endcase
        if (last) begin
            // An early end replaces whatever this byte would have reported.
            if (cur_phase != PH_DONE) begin
                rec      = '0;
                rec.kind = KIND_TRUNCATED;
                made     = 1'b1;
            end
            clear_parser();
        end
        if (made) begin
            pending_records.push_back(rec);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
            end
        end
    endtask

    task automatic check_record(input result_t got);
        result_t want;
        if (pending_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: result of kind %0d arrived with none pending", $time, got.kind);
            end
            return;
        end
        want = pending_records.pop_front();
        compare_field("kind", 64'(want.kind), 64'(got.kind));
        compare_field("ident_or_type", 64'(want.ident_or_type), 64'(got.ident_or_type));
        compare_field("flags_or_class", 64'(want.flags_or_class), 64'(got.flags_or_class));
        compare_field("time_to_live", 64'(want.time_to_live), 64'(got.time_to_live));
        compare_field("data_length", 64'(want.data_length), 64'(got.data_length));
        compare_field("question_total", 64'(want.question_total), 64'(got.question_total));
        compare_field("answer_total", 64'(want.answer_total), 64'(got.answer_total));
        compare_field("address_high", want.address_high, got.address_high);
        compare_field("address_low", want.address_low, got.address_low);
        compare_field("name_compressed", 64'(want.name_compressed),
                      64'(got.name_compressed));
        compare_field("name_pointer", 64'(want.name_pointer), 64'(got.name_pointer));
        compare_field("name_length", 64'(want.name_length), 64'(got.name_length));
    endtask

    // Byte transactions are modelled before results are checked, so a result
    // can never overtake the byte that caused it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_dns_byte(s_data_byte, s_end_of_message);
            end
            if (m_valid && m_ready) begin
                check_record(seen_record);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idling and back-pressure
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (ready_idling && m_ready && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Byte sender and message building
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = send_idling ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= value;
        s_end_of_message <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++) begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
        msg_bytes.delete();
    endtask

    task automatic put8(input logic [7:0] value);
        msg_bytes.push_back(value);
    endtask

    task automatic put16(input logic [15:0] value);
        put8(value[15:8]);
        put8(value[7:0]);
    endtask

    task automatic put_header(input logic [15:0] ident, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an);
        put16(ident);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic put_label(input logic [7:0] len_byte);
        put8(len_byte);
        repeat (len_byte & LABEL_MASK) put8(8'($urandom));
    endtask

    task automatic put_pointer(input logic [13:0] offset);
        put8(PTR_MARK | {2'b00, offset[13:8]});
        put8(offset[7:0]);
    endtask

    task automatic put_answer(input logic [15:0] code, input logic [15:0] cls,
                              input logic [31:0] ttl, input logic [15:0] rdlen);
        logic [15:0] n;
        put16(code);
        put16(cls);
        put16(ttl[31:16]);
        put16(ttl[15:0]);
        put16(rdlen);
        if (code == TYPE_A) begin
            n = A_ADDR_LEN;
        end else if (code == TYPE_AAAA) begin
            n = AAAA_ADDR_LEN;
        end else begin
            n = rdlen;
        end
        repeat (n) put8(8'($urandom));
    endtask

    task automatic put_random_name();
        int unsigned r;
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                put_label(8'($urandom_range(1, 12)));
            end else if (r < 9) begin
                put_label(8'($urandom_range(1, 63)));
            end else begin
                put_label({2'($urandom_range(1, 2)), 6'($urandom_range(0, 63))});
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            put_pointer(14'($urandom));
        end else begin
            put8(8'h00);
        end
    endtask

    task automatic cut_message(input int unsigned keep);
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_header_extremes();
        put_header(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_message();
        // Maximum counts can never be satisfied, so the message ends early.
        put_header(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        put_label(8'h03);
        send_message();
        put8(8'($urandom));
        send_message();
    endtask

    task automatic test_label_forms();
        put_header(16'($urandom), 16'($urandom), 16'd1, 16'd0);
        put_label(8'h3F);
        put_label(8'h40);
        put_label(8'h85);
        put_label(8'h80);
        put_label(8'h01);
        put8(8'h00);
        put16(16'hFFFF);
        put16(16'hFFFF);
        send_message();
        // A long name saturates the character count; a bare root name follows.
        put_header(16'($urandom), 16'($urandom), 16'd2, 16'd0);
        repeat (5) put_label(8'h3F);
        put8(8'h00);
        put16(16'h0000);
        put16(16'h0000);
        put8(8'h00);
        put16(TYPE_A);
        put16(16'h0001);
        send_message();
    endtask

    task automatic test_pointer_names();
        put_header(16'($urandom), 16'($urandom), 16'd2, 16'd1);
        put_pointer(14'h3FFF);
        put16(16'($urandom));
        put16(16'($urandom));
        put_label(8'h04);
        put_pointer(14'h000C);
        put16(16'($urandom));
        put16(16'($urandom));
        put_pointer(14'h0000);
        put_answer(16'h0010, 16'h0001, 32'h0000_0000, 16'h0000);
        send_message();
    endtask

    task automatic test_address_records();
        put_header(16'($urandom), 16'($urandom), 16'd0, 16'd6);
        put_random_name();
        put_answer(TYPE_A, 16'h0001, 32'hFFFF_FFFF, A_ADDR_LEN);
        put_label(8'h02);
        put8(8'h00);
        put_answer(TYPE_A, 16'hFFFF, 32'h0000_0000, 16'hFFFF);
        put_pointer(14'($urandom));
        put_answer(TYPE_AAAA, 16'h0001, $urandom, AAAA_ADDR_LEN);
        put8(8'h00);
        put_answer(TYPE_AAAA, 16'h0001, $urandom, 16'h0003);
        put8(8'h00);
        put_answer(16'hFFFF, 16'hFFFF, $urandom, 16'h0005);
        put8(8'h00);
        put_answer(16'h0000, 16'h0000, 32'h0000_0000, 16'h0001);
        send_message();
    endtask

    task automatic test_truncation();
        // Cut points: inside the question name, on the last question byte
        // with an answer still owed, inside the pointer, inside the fixed
        // answer fields, inside the address, and the complete message.
        int unsigned cuts[6];
        cuts = '{15, 23, 24, 30, 37, 39};
        foreach (cuts[i]) begin
            put_header(16'($urandom), 16'($urandom), 16'd1, 16'd1);
            put_label(8'h05);
            put8(8'h00);
            put16(16'($urandom));
            put16(16'($urandom));
            put_pointer(14'($urandom));
            put_answer(TYPE_A, 16'h0001, $urandom, A_ADDR_LEN);
            cut_message(cuts[i]);
            send_message();
        end
    endtask

    task automatic test_trailing_bytes();
        put_header(16'($urandom), 16'($urandom), 16'd1, 16'd1);
        put_random_name();
        put16(16'($urandom));
        put16(16'($urandom));
        put_random_name();
        put_answer(TYPE_A, 16'h0001, $urandom, A_ADDR_LEN);
        repeat (10) put8(8'($urandom));
        send_message();
        // The next message must start again from a clean header.
        put_header(16'($urandom), 16'($urandom), 16'd0, 16'd1);
        put8(8'h00);
        put_answer(TYPE_AAAA, 16'h0001, $urandom, AAAA_ADDR_LEN);
        send_message();
    endtask

    task automatic test_random_messages();
        int unsigned start;
        int unsigned mode;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] ans_type;
        logic [15:0] ans_len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            send_idling  = ($urandom_range(0, 3) != 0);
            ready_idling = ($urandom_range(0, 3) != 0);
            mode         = $urandom_range(0, 9);
            if (mode == 0) begin
                repeat ($urandom_range(1, 30)) put8(8'($urandom));
            end else begin
                qd = 16'($urandom_range(0, 3));
                an = 16'($urandom_range(0, 3));
                put_header(16'($urandom), 16'($urandom), qd, an);
                repeat (qd) begin
                    put_random_name();
                    put16(16'($urandom));
                    put16(16'($urandom));
                end
                repeat (an) begin
                    put_random_name();
                    case ($urandom_range(0, 2))
                        0:       ans_type = TYPE_A;
                        1:       ans_type = TYPE_AAAA;
                        default: ans_type = 16'($urandom);
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        ans_len = 16'($urandom_range(0, 20));
                    end else if (ans_type == TYPE_A) begin
                        ans_len = A_ADDR_LEN;
                    end else if (ans_type == TYPE_AAAA) begin
                        ans_len = AAAA_ADDR_LEN;
                    end else begin
                        ans_len = 16'($urandom_range(0, 10));
                    end
                    put_answer(ans_type, 16'($urandom), $urandom, ans_len);
                end
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 6)) put8(8'($urandom));
                end
                if (mode <= 2) begin
                    cut_message($urandom_range(1, msg_bytes.size()));
                end
            end
            send_message();
        end
    endtask

    initial begin
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_header_extremes();
        send_idling  = 1'b1;
        ready_idling = 1'b1;
        test_label_forms();
        test_pointer_names();
        test_address_records();
        test_truncation();
        test_trailing_bytes();
        test_random_messages();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_records.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dnsmp_pkg.sv
rtl/dnsmp_parse.sv
rtl/dns_message_parser_core.sv
tb/tb_dns_message_parser_core.sv
